// ----- hdl/hmtp_pkg.sv -----
// ----------------------------------------------------------------------------
// hmtp_pkg
// Shared types and constants of the triangular-probe hash map.
// ----------------------------------------------------------------------------
package hmtp_pkg;

    localparam int KEY_W   = 32;
    localparam int PROBE_W = 12;
    localparam int MODE_W  = 2;
    localparam int HASH_W  = 31;

    localparam logic [PROBE_W-1:0] PROBE_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_MURMUR   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_XORSHIFT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_IDENTITY = 2'd2;

    localparam logic [KEY_W-1:0] MIX_C1 = 32'd2246822507;
    localparam logic [KEY_W-1:0] MIX_C2 = 32'd3266489909;

    localparam logic [0:0] OP_SET = 1'b0;
    localparam logic [0:0] OP_GET = 1'b1;

    typedef logic [KEY_W-1:0] t_word;

endpackage

// ----- hdl/hmtp_if.sv -----
// ----------------------------------------------------------------------------
// hmtp_if
// Channel interfaces: operation requests, results and the mode register.
// ----------------------------------------------------------------------------
interface hmtp_in_if;
    import hmtp_pkg::*;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [31:0] key;
    logic signed [31:0] new_value;
    logic signed [31:0] fallback;
    modport source (output valid, operation, key, new_value, fallback, input ready);
    modport sink   (input valid, operation, key, new_value, fallback, output ready);
endinterface

interface hmtp_out_if;
    logic               valid;
    logic               ready;
    logic               existed;
    logic signed [31:0] read_value;
    logic [11:0]        probe_count;
    logic               table_full;
    modport source (output valid, existed, read_value, probe_count, table_full,
                    input ready);
    modport sink   (input valid, existed, read_value, probe_count, table_full,
                    output ready);
endinterface

interface hmtp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- hdl/hmtp_hash.sv -----
// ----------------------------------------------------------------------------
// hmtp_hash
// Key mixer with one shared 32x32 multiplier, used twice for the murmur mix.
// ----------------------------------------------------------------------------
module hmtp_hash
    import hmtp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MODE_W-1:0] i_mode,
    input  t_word             i_key,
    output logic              o_done,
    output logic [HASH_W-1:0] o_hash
);

    localparam logic [1:0] H_IDLE = 2'd0;
    localparam logic [1:0] H_M1   = 2'd1;
    localparam logic [1:0] H_M2   = 2'd2;

    logic [1:0] r_state, n_state;
    t_word      r_h, n_h;
    logic       r_done, n_done;
    t_word      w_mul_b, w_prod;

    assign w_mul_b = (r_state == H_M1) ? MIX_C1 : MIX_C2;
    assign w_prod  = r_h * w_mul_b;

    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_done  = 1'b0;
        unique case (r_state)
            H_IDLE: begin
                if (i_start) begin
                    if (i_mode == MODE_MURMUR || i_mode == MODE_XORSHIFT) begin
                        n_h = i_key ^ (i_key >> 16);
                    end else begin
                        n_h = i_key;
                    end
                    if (i_mode == MODE_MURMUR) begin
                        n_state = H_M1;
                    end else begin
                        n_done = 1'b1;
                    end
                end
            end
            H_M1: begin
                n_h     = w_prod ^ (w_prod >> 13);
                n_state = H_M2;
            end
            H_M2: begin
                n_h     = w_prod ^ (w_prod >> 16);
                n_done  = 1'b1;
                n_state = H_IDLE;
            end
            default: n_state = H_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_h <= n_h;
    end

    assign o_done = r_done;
    assign o_hash = r_h[HASH_W-1:0];

endmodule

// ----- hdl/hash_map_triangular_probe_top.sv -----
// ----------------------------------------------------------------------------
// hash_map_triangular_probe_top
// Integer key to value map with triangular probing and growth by rehash.
// ----------------------------------------------------------------------------
// Usage: requests arrive on i_in (set or get of a key), one result beat per
// request leaves on o_out, and i_cfg writes the hash mode. A mode beat is
// taken only while the map is idle and wins over a request in that cycle.
// After reset the slot table is swept empty, one slot a cycle, and
// i_in.ready stays low until the sweep is done.
// A request is hashed (longest in murmur mode), then each occupied slot it
// meets costs a slot read, a slot check and a key compare, and the empty
// slot that ends a walk a slot read and a slot check; a finish step follows
// (after a value read for a hit get, or a decision step for a miss), and the
// map returns to idle before it takes the next beat. The single port of the
// slot table and of the key store paces the probing.
// A set that pushes occupancy past half doubles the table, if the doubled
// table fits MAX_SLOTS, and reinserts all entries: per entry a key read, a
// hash start, the hash and a slot read and slot check per probe, done after
// the result is handed over; no request is taken meanwhile.
// The result is held in an output register; when the receiver stalls, the
// map finishes the current request and waits with i_in.ready low.
// ----------------------------------------------------------------------------
module hash_map_triangular_probe_top
    import hmtp_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_SLOTS   = 2048
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    hmtp_in_if.sink     i_in,
    hmtp_out_if.source  o_out,
    hmtp_cfg_if.sink    i_cfg
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = $clog2(MAX_SLOTS);
    localparam int EW = $clog2($clog2(MAX_SLOTS) + 1);
    localparam int DW = 1 + EW + IW;

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_HASH  = 4'd2;
    localparam logic [3:0] ST_SRD   = 4'd3;
    localparam logic [3:0] ST_SCHK  = 4'd4;
    localparam logic [3:0] ST_KCHK  = 4'd5;
    localparam logic [3:0] ST_VRD   = 4'd6;
    localparam logic [3:0] ST_DEC   = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;
    localparam logic [3:0] ST_GRD   = 4'd9;
    localparam logic [3:0] ST_GKEY  = 4'd10;
    localparam logic [3:0] ST_GHASH = 4'd11;
    localparam logic [3:0] ST_GSRD  = 4'd12;
    localparam logic [3:0] ST_GSCHK = 4'd13;

    // Memories; slot words are {valid, epoch, entry index}.
    logic [DW-1:0] slot_mem [MAX_SLOTS];
    t_word         key_mem  [MAX_ENTRIES];
    t_word         val_mem  [MAX_ENTRIES];

    logic [3:0]        r_state, n_state;
    logic [MODE_W-1:0] r_mode;
    logic [SW-1:0]     r_clr, n_clr;
    logic [SW-1:0]     r_mask, n_mask;
    logic [EW-1:0]     r_epoch, n_epoch;
    logic [CW-1:0]     r_count, n_count;
    logic [SW-1:0]     r_at, n_at;
    logic [SW-1:0]     r_step, n_step;
    logic [SW:0]       r_n, n_n;
    logic [PROBE_W-1:0] r_probes, n_probes;
    logic [SW-1:0]     r_slot, n_slot;
    logic              r_empty_ok, n_empty_ok;
    logic [IW-1:0]     r_ent, n_ent;
    logic [IW-1:0]     r_e, n_e;
    logic              r_last, n_last;
    logic              r_grow, n_grow;
    logic              r_op;
    t_word             r_key, r_nv, r_fb;
    logic              r_existed, n_existed;
    t_word             r_rd, n_rd;
    logic              r_full, n_full;

    logic              r_out_valid, n_out_valid;
    logic              r_o_existed, r_o_full;
    t_word             r_o_rd;
    logic [PROBE_W-1:0] r_o_probes;

    logic [DW-1:0] r_slot_q;
    t_word         r_key_q, r_val_q;

    // Memory port controls.
    logic          w_slot_we;
    logic [SW-1:0] w_slot_addr;
    logic [DW-1:0] w_slot_wd;
    logic          w_key_we;
    logic [IW-1:0] w_key_addr;
    logic          w_val_we;
    logic [IW-1:0] w_val_addr;
    t_word         w_val_wd;

    logic              w_hstart, w_hdone;
    t_word             w_hkey;
    logic [HASH_W-1:0] w_hash;

    logic          w_accept, w_load;
    logic [SW:0]   w_size;
    logic          w_slot_live;
    logic [IW-1:0] w_slot_ent;
    logic [SW-1:0] w_next_at;
    logic [SW:0]   w_n_inc;
    logic [IW-1:0] w_cnt_idx;

    assign w_size      = {1'b0, r_mask} + (SW+1)'(1);
    assign w_slot_live = r_slot_q[DW-1] && (r_slot_q[DW-2 -: EW] == r_epoch);
    assign w_slot_ent  = r_slot_q[IW-1:0];
    assign w_next_at   = (r_at + r_step) & r_mask;
    assign w_n_inc     = r_n + (SW+1)'(1);
    assign w_cnt_idx   = r_count[IW-1:0];
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_load      = (r_state == ST_FIN) && (!r_out_valid || o_out.ready);

    // A mode beat is taken alone, so a request never sees a mode change mid-way.
    assign i_in.ready  = (r_state == ST_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = (r_state == ST_IDLE);

    assign w_hstart = w_accept || (r_state == ST_GKEY);
    assign w_hkey   = (r_state == ST_GKEY) ? r_key_q : t_word'(i_in.key);

    hmtp_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hstart),
        .i_mode  (r_mode),
        .i_key   (w_hkey),
        .o_done  (w_hdone),
        .o_hash  (w_hash)
    );

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_mask     = r_mask;
        n_epoch    = r_epoch;
        n_count    = r_count;
        n_at       = r_at;
        n_step     = r_step;
        n_n        = r_n;
        n_probes   = r_probes;
        n_slot     = r_slot;
        n_empty_ok = r_empty_ok;
        n_ent      = r_ent;
        n_e        = r_e;
        n_last     = r_last;
        n_grow     = r_grow;
        n_existed  = r_existed;
        n_rd       = r_rd;
        n_full     = r_full;

        w_slot_we   = 1'b0;
        w_slot_addr = r_at;
        w_slot_wd   = '0;
        w_key_we    = 1'b0;
        w_key_addr  = w_slot_ent;
        w_val_we    = 1'b0;
        w_val_addr  = w_slot_ent;
        w_val_wd    = r_nv;

        unique case (r_state)
            ST_CLR: begin
                w_slot_we   = 1'b1;
                w_slot_addr = r_clr;
                n_clr       = r_clr + SW'(1);
                if (r_clr == SW'(MAX_SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state    = ST_HASH;
                    n_probes   = '0;
                    n_empty_ok = 1'b0;
                    n_existed  = 1'b0;
                    n_full     = 1'b0;
                    n_rd       = '0;
                    n_grow     = 1'b0;
                end
            end
            ST_HASH: begin
                if (w_hdone) begin
                    n_at    = w_hash[SW-1:0] & r_mask;
                    n_step  = SW'(1);
                    n_n     = '0;
                    n_state = ST_SRD;
                end
            end
            ST_SRD: begin
                n_state = ST_SCHK;
            end
            ST_SCHK: begin
                n_n = w_n_inc;
                if (r_probes != PROBE_MAX) begin
                    n_probes = r_probes + PROBE_W'(1);
                end
                if (!w_slot_live) begin
                    n_slot     = r_at;
                    n_empty_ok = 1'b1;
                    n_state    = ST_DEC;
                end else begin
                    // Key store read of the entry this slot points at.
                    w_key_addr = w_slot_ent;
                    n_ent      = w_slot_ent;
                    n_state    = ST_KCHK;
                end
            end
            ST_KCHK: begin
                if (r_key_q == r_key) begin
                    n_existed = 1'b1;
                    if (r_op == OP_GET) begin
                        w_val_addr = r_ent;
                        n_state    = ST_VRD;
                    end else begin
                        w_val_we   = 1'b1;
                        w_val_addr = r_ent;
                        n_state    = ST_FIN;
                    end
                end else begin
                    n_at   = w_next_at;
                    n_step = r_step + SW'(1);
                    if (r_n == w_size) begin
                        n_state = ST_DEC;
                    end else begin
                        n_state = ST_SRD;
                    end
                end
            end
            ST_VRD: begin
                n_rd    = r_val_q;
                n_state = ST_FIN;
            end
            ST_DEC: begin
                n_state = ST_FIN;
                if (r_op == OP_GET) begin
                    n_rd = r_fb;
                end else if (32'(r_count) >= MAX_ENTRIES || !r_empty_ok) begin
                    n_full = 1'b1;
                end else begin
                    w_key_we    = 1'b1;
                    w_key_addr  = w_cnt_idx;
                    w_val_we    = 1'b1;
                    w_val_addr  = w_cnt_idx;
                    w_slot_we   = 1'b1;
                    w_slot_addr = r_slot;
                    w_slot_wd   = {1'b1, r_epoch, w_cnt_idx};
                    n_count     = r_count + CW'(1);
                    if ((32'(r_count) + 1) > (32'(w_size) >> 1) &&
                        32'(w_size) <= MAX_SLOTS / 2) begin
                        n_grow = 1'b1;
                    end
                end
            end
            ST_FIN: begin
                if (w_load) begin
                    if (r_grow) begin
                        // Doubling: bumping the epoch empties every slot at once.
                        n_mask  = {r_mask[SW-2:0], 1'b1};
                        n_epoch = r_epoch + EW'(1);
                        n_e     = '0;
                        n_state = ST_GRD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_GRD: begin
                w_key_addr = r_e;
                n_state    = ST_GKEY;
            end
            ST_GKEY: begin
                n_state = ST_GHASH;
            end
            ST_GHASH: begin
                if (w_hdone) begin
                    n_at    = w_hash[SW-1:0] & r_mask;
                    n_step  = SW'(1);
                    n_n     = '0;
                    n_last  = 1'b0;
                    n_state = ST_GSRD;
                end
            end
            ST_GSRD: begin
                n_state = ST_GSCHK;
            end
            ST_GSCHK: begin
                if (!w_slot_live || r_last) begin
                    if (!w_slot_live) begin
                        w_slot_we   = 1'b1;
                        w_slot_addr = r_at;
                        w_slot_wd   = {1'b1, r_epoch, r_e};
                    end
                    n_e = r_e + IW'(1);
                    if ((32'(r_e) + 1) == 32'(r_count)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_GRD;
                    end
                end else begin
                    // After a full lap the final position is still checked once.
                    n_n     = w_n_inc;
                    n_at    = w_next_at;
                    n_step  = r_step + SW'(1);
                    n_last  = (w_n_inc == w_size);
                    n_state = ST_GSRD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_mode      <= MODE_MURMUR;
            r_clr       <= '0;
            r_mask      <= SW'(7);
            r_epoch     <= '0;
            r_count     <= '0;
            r_grow      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_mask      <= n_mask;
            r_epoch     <= n_epoch;
            r_count     <= n_count;
            r_grow      <= n_grow;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_mode <= i_cfg.data;
            end
        end
        r_at       <= n_at;
        r_step     <= n_step;
        r_n        <= n_n;
        r_probes   <= n_probes;
        r_slot     <= n_slot;
        r_empty_ok <= n_empty_ok;
        r_ent      <= n_ent;
        r_e        <= n_e;
        r_last     <= n_last;
        r_existed  <= n_existed;
        r_rd       <= n_rd;
        r_full     <= n_full;
        if (w_accept) begin
            r_op  <= i_in.operation;
            r_key <= t_word'(i_in.key);
            r_nv  <= t_word'(i_in.new_value);
            r_fb  <= t_word'(i_in.fallback);
        end
        if (w_load) begin
            r_o_existed <= r_existed;
            r_o_rd      <= r_rd;
            r_o_probes  <= r_probes;
            r_o_full    <= r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            slot_mem[w_slot_addr] <= w_slot_wd;
        end
        r_slot_q <= slot_mem[w_slot_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            key_mem[w_key_addr] <= r_key;
        end
        r_key_q <= key_mem[w_key_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_val_we) begin
            val_mem[w_val_addr] <= w_val_wd;
        end
        r_val_q <= val_mem[w_val_addr];
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.existed     = r_o_existed;
    assign o_out.read_value  = r_o_rd;
    assign o_out.probe_count = r_o_probes;
    assign o_out.table_full  = r_o_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MAX_ENTRIES)
        else $error("entry count beyond capacity");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request accepted while another is in work");

    a_full_not_existed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.table_full && o_out.existed))
        else $error("refused insert reported as present key");

    a_mask_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mask & (r_mask + SW'(1))) == '0)
        else $error("slot mask is not a power of two minus one");

endmodule

// ----- verif/tb_hash_map_triangular_probe_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hash_map_triangular_probe_top
// Checks the triangular-probe hash map against an independent model of it.
// Directed sets and gets come first, then random traffic over all four mode
// codes, with idle gaps and backpressure on both channels.
// ----------------------------------------------------------------------------
module tb_hash_map_triangular_probe_top;
    import hmtp_pkg::*;

    localparam int NUM_ENTRIES = 1024;
    localparam int NUM_SLOTS   = 2048;
    localparam int CYCLE_LIMIT = 3_000_000;

    // The mode register's fourth code is reserved and behaves as identity.
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    typedef struct packed {
        logic        existed;
        logic [31:0] read_value;
        logic [11:0] probe_count;
        logic        table_full;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    hmtp_in_if  req_ch ();
    hmtp_out_if rsp_ch ();
    hmtp_cfg_if cfg_ch ();

    hash_map_triangular_probe_top #(
        .MAX_ENTRIES(NUM_ENTRIES),
        .MAX_SLOTS  (NUM_SLOTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch.sink),
        .o_out  (rsp_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    // Map model state.
    logic [1:0]  mdl_mode;
    logic [10:0] mdl_slot_ent [NUM_SLOTS];
    logic        mdl_slot_used[NUM_SLOTS];
    logic [31:0] mdl_keys     [NUM_ENTRIES];
    logic [31:0] mdl_vals     [NUM_ENTRIES];
    int unsigned mdl_count;
    int unsigned mdl_mask;

    t_answer     answers_due[$];
    int          mismatches;
    int          results_seen;
    int          sent_items;
    int unsigned cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic [31:0] used_keys[$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [31:0] mix_key(logic [31:0] k);
        logic [31:0] h;
        h = k;
        if (mdl_mode == MODE_MURMUR) begin
            h = h ^ (h >> 16);
            h = h * MIX_C1;
            h = h ^ (h >> 13);
            h = h * MIX_C2;
            h = h ^ (h >> 16);
        end else if (mdl_mode == MODE_XORSHIFT) begin
            h = h ^ (h >> 16);
        end
        return h & 32'h7fff_ffff;
    endfunction

    function automatic void mdl_clear();
        for (int i = 0; i < NUM_SLOTS; i++) mdl_slot_used[i] = 1'b0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            mdl_keys[i] = '0;
            mdl_vals[i] = '0;
        end
        mdl_count = 0;
        mdl_mask  = 7;
        mdl_mode  = MODE_MURMUR;
    endfunction

    function automatic void mdl_grow();
        int unsigned size;
        int unsigned at;
        int unsigned step;
        int unsigned n;
        size = (mdl_mask + 1) * 2;
        for (int i = 0; i < NUM_SLOTS; i++) mdl_slot_used[i] = 1'b0;
        mdl_mask = size - 1;
        for (int unsigned e = 0; e < mdl_count; e++) begin
            at = mix_key(mdl_keys[e]) & mdl_mask;
            step = 1;
            n = 0;
            while (n < size && mdl_slot_used[at]) begin
                at = (at + step) & mdl_mask;
                step++;
                n++;
            end
            if (!mdl_slot_used[at]) begin
                mdl_slot_used[at] = 1'b1;
                mdl_slot_ent[at] = e[10:0];
            end
        end
    endfunction

    // Applies one request to the model and returns the answer it must give.
    function automatic t_answer map_access(logic op, logic [31:0] k,
                                           logic [31:0] nv, logic [31:0] fb);
        t_answer     a;
        int unsigned size;
        int unsigned at;
        int unsigned step;
        int unsigned probes;
        int unsigned ent;
        int unsigned free_at;
        logic        found;
        logic        has_free;
        size = mdl_mask + 1;
        at = mix_key(k) & mdl_mask;
        step = 1;
        probes = 0;
        found = 1'b0;
        has_free = 1'b0;
        ent = 0;
        free_at = 0;
        for (int unsigned n = 0; n < size; n++) begin
            probes++;
            if (!mdl_slot_used[at]) begin
                has_free = 1'b1;
                free_at = at;
                break;
            end
            if (mdl_keys[mdl_slot_ent[at] % NUM_ENTRIES] == k) begin
                found = 1'b1;
                ent = mdl_slot_ent[at] % NUM_ENTRIES;
                break;
            end
            at = (at + step) & mdl_mask;
            step++;
        end
        a = '0;
        a.existed = found;
        if (op == OP_GET) begin
            a.read_value = found ? mdl_vals[ent] : fb;
        end else if (found) begin
            mdl_vals[ent] = nv;
        end else if (mdl_count >= NUM_ENTRIES || !has_free) begin
            a.table_full = 1'b1;
        end else begin
            mdl_keys[mdl_count] = k;
            mdl_vals[mdl_count] = nv;
            mdl_slot_ent[free_at] = mdl_count[10:0];
            mdl_slot_used[free_at] = 1'b1;
            mdl_count++;
            if (mdl_count > (mdl_mask + 1) / 2 && (mdl_mask + 1) <= NUM_SLOTS / 2)
                mdl_grow();
        end
        a.probe_count = (probes > 4095) ? 12'hfff : probes[11:0];
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
    endtask

    // Result checker with random backpressure.
    initial begin
        t_answer want;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("unexpected beat", 0, 0);
                end else begin
                    want = answers_due.pop_front();
                    if (rsp_ch.existed !== want.existed)
                        report_mismatch("existed", rsp_ch.existed, want.existed);
                    if (rsp_ch.read_value !== want.read_value)
                        report_mismatch("read_value", rsp_ch.read_value, want.read_value);
                    if (rsp_ch.probe_count !== want.probe_count)
                        report_mismatch("probe_count", rsp_ch.probe_count,
                                        want.probe_count);
                    if (rsp_ch.table_full !== want.table_full)
                        report_mismatch("table_full", rsp_ch.table_full, want.table_full);
                end
                results_seen++;
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Valid stays high from one beat to the next unless an idle gap is drawn.
    task automatic send_request(logic op, logic [31:0] k, logic [31:0] nv,
                                logic [31:0] fb);
        if ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.key       <= k;
        req_ch.new_value <= nv;
        req_ch.fallback  <= fb;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        answers_due.push_back(map_access(op, k, nv, fb));
        sent_items++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        // Growth rehash runs after the result beat; give it time to finish.
        repeat (40000) @(posedge i_clk);
    endtask

    task automatic write_mode(logic [1:0] m);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= m;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        mdl_mode = m;
    endtask

    function automatic logic [31:0] pick_key();
        if (used_keys.size() != 0 && $urandom_range(99) < 55)
            return used_keys[$urandom_range(used_keys.size() - 1)];
        return $urandom();
    endfunction

    // Field extremes, both operations, overwrite and absent-key fallback.
    task automatic test_directed();
        logic [31:0] corner[6] = '{32'h0, 32'hffff_ffff, 32'h8000_0000,
                                   32'h7fff_ffff, 32'h0001_0000, 32'h5555_aaaa};
        foreach (corner[i]) send_request(OP_SET, corner[i], ~corner[i], '0);
        foreach (corner[i]) send_request(OP_GET, corner[i], '0, 32'hdead_beef);
        send_request(OP_SET, 32'h8000_0000, 32'h7fff_ffff, '0);
        send_request(OP_GET, 32'h8000_0000, '0, '0);
        send_request(OP_GET, 32'h1234_5678, 32'hffff_ffff, 32'h8000_0000);
        send_request(OP_GET, 32'h1234_5679, '0, 32'h7fff_ffff);
        send_request(OP_SET, 32'h0000_0008, 32'hffff_ffff, 32'hffff_ffff);
        send_request(OP_SET, 32'h0000_0010, 32'h1, 32'h0);
        drain();
    endtask

    // Random traffic; mostly reused keys so that gets hit and sets update.
    task automatic test_random(int n_items);
        logic [31:0] k;
        logic        op;
        for (int i = 0; i < n_items; i++) begin
            k = pick_key();
            op = 1'($urandom_range(1));
            if (op == OP_SET && used_keys.size() < 900) used_keys.push_back(k);
            send_request(op, k, $urandom(), $urandom());
        end
        drain();
    endtask

    // Fill the entry store with fresh keys so that refusals appear.
    task automatic test_store_full();
        int n_fill;
        n_fill = NUM_ENTRIES + 8 - int'(mdl_count);
        for (int i = 0; i < n_fill; i++)
            send_request(OP_SET, 32'h4000_0000 + i * 3, i, '0);
        send_request(OP_SET, 32'h4000_0000, 32'habcd, '0);
        send_request(OP_SET, 32'h7fff_fff0, 32'h1, '0);
        for (int i = 0; i < 60; i++)
            send_request(OP_GET, pick_key(), '0, $urandom());
        drain();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_SET;
        req_ch.key       = '0;
        req_ch.new_value = '0;
        req_ch.fallback  = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = MODE_MURMUR;
        cycles           = 0;
        mismatches       = 0;
        results_seen     = 0;
        sent_items       = 0;
        send_idle_pct    = 12;
        recv_idle_pct    = 66;
        mdl_clear();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        write_mode(MODE_XORSHIFT);
        test_random(100);
        send_idle_pct = 66;
        recv_idle_pct = 12;
        write_mode(MODE_IDENTITY);
        test_random(100);
        write_mode(MODE_RESERVED);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(50);
        write_mode(MODE_MURMUR);
        test_store_full();

        $display("covered %0d requests and %0d results over hash modes 0 to 3",
                 sent_items, results_seen);
        $display("map held %0d entries at the end, slot mask %0d", mdl_count, mdl_mask);
        if (mismatches == 0 && answers_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/hmtp_pkg.sv
hdl/hmtp_if.sv
hdl/hmtp_hash.sv
hdl/hash_map_triangular_probe_top.sv
verif/tb_hash_map_triangular_probe_top.sv
